FILE: sv/pwl_pkg.sv
// Shared constants for the pulse width link controller.
// Used by the channel interfaces and the top level; no dependencies.
`default_nettype none

package pwl_pkg;

  // Message and queue geometry
  localparam int unsigned MsgBits    = 88;
  localparam int unsigned LowW       = 64;
  localparam int unsigned HighW      = 24;
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned QIdxW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW      = $clog2(QueueDepth + 1);

  // Channel field widths
  localparam int unsigned ReqW       = 2;
  localparam int unsigned PulseW     = 16;
  localparam int unsigned LevelW     = 4;
  localparam int unsigned PhaseW     = 3;
  localparam int unsigned BitPosW    = 7;

  // Header layout
  localparam int unsigned HeaderLen  = 8;
  localparam int unsigned PosReady   = 1;
  localparam int unsigned PosPending = 4;
  localparam int unsigned PosInit    = 7;
  localparam int unsigned HdrDataBit = 0;
  localparam int unsigned HdrCedeBit = 4;

  // Request codes
  localparam logic [ReqW-1:0] ReqPulse = 2'd0;
  localparam logic [ReqW-1:0] ReqLoad  = 2'd1;
  localparam logic [ReqW-1:0] ReqPop   = 2'd2;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgPresyncMin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPresyncMax = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSyncMin    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSyncMax    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgZeroMin    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgZeroMax    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgReady      = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgInit       = 3'd7;

endpackage

`default_nettype wire

FILE: sv/pwl_if.sv
// Valid/ready channels of the pulse width link controller: request and result.
// Depends on pwl_pkg for field widths.
`default_nettype none

interface pwl_req_if;
  logic                        valid;
  logic                        ready;
  logic [pwl_pkg::ReqW-1:0]    req_type;
  logic [pwl_pkg::PulseW-1:0]  pulse_width;
  logic [pwl_pkg::LowW-1:0]    out_low;
  logic [pwl_pkg::HighW-1:0]   out_high;

  modport source (output valid, req_type, pulse_width, out_low, out_high, input ready);
  modport sink (input valid, req_type, pulse_width, out_low, out_high, output ready);
endinterface

interface pwl_res_if;
  logic                        valid;
  logic                        ready;
  logic                        drive_pulse;
  logic                        msg_valid;
  logic [pwl_pkg::LowW-1:0]    msg_low;
  logic [pwl_pkg::HighW-1:0]   msg_high;
  logic                        dropped;
  logic [pwl_pkg::LevelW-1:0]  queue_level;
  logic [pwl_pkg::PhaseW-1:0]  link_phase;

  modport source (output valid, drive_pulse, msg_valid, msg_low, msg_high, dropped,
                  queue_level, link_phase, input ready);
  modport sink (input valid, drive_pulse, msg_valid, msg_low, msg_high, dropped,
                queue_level, link_phase, output ready);
endinterface

`default_nettype wire

FILE: sv/pulse_width_link_controller.sv
// Pulse width link controller, remote side: link state machine, outbound
// shift register, receive shift register and received-message queue.
// Depends on pwl_pkg and the channel interfaces in pwl_if.sv.
// The result is registered and is valid in the cycle after the request transfer.
// Throughput: one request per cycle while results are taken; the result register frees as it is taken.
// Reset clears link state, queue pointers and the result valid; registers
// 0-5 reset to 0, ready_flag_q and init_flag_q to 1. Queue entries
// hold no reset value and are only read after being written.
`default_nettype none

module pulse_width_link_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pwl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pwl_pkg::CfgDataW-1:0]  cfg_data_i,
  pwl_req_if.sink                       req_i,
  pwl_res_if.source                     res_o
);

  typedef enum logic [pwl_pkg::PhaseW-1:0] {
    PhAwait     = 3'd0,
    PhPresync   = 3'd1,
    PhRemoteHdr = 3'd2,
    PhPlayerHdr = 3'd3,
    PhReceive   = 3'd4,
    PhSend      = 3'd5
  } phase_e;

  typedef logic [pwl_pkg::MsgBits-1:0] msg_t;

  // Configuration
  logic [pwl_pkg::PulseW-1:0] presync_min_q, presync_max_q, sync_min_q, sync_max_q;
  logic [pwl_pkg::PulseW-1:0] zero_min_q, zero_max_q;
  logic                       ready_flag_q, init_flag_q;

  // Link state
  phase_e                        phase_q, phase_d;
  logic [pwl_pkg::BitPosW-1:0]   bitpos_q, bitpos_d;
  logic [pwl_pkg::HeaderLen-1:0] header_q, header_d;
  msg_t                          rx_q, rx_d;
  msg_t                          tx_q, tx_d;
  logic                          pending_q, pending_d;

  // Queue
  msg_t                          store_q [pwl_pkg::QueueDepth];
  logic [pwl_pkg::QIdxW-1:0]     head_q, head_d;
  logic [pwl_pkg::FillW-1:0]     fill_q, fill_d;
  logic [pwl_pkg::QIdxW:0]       tail_sum;
  logic [pwl_pkg::QIdxW-1:0]     tail;
  logic                          push;
  msg_t                          rx_full;

  // Result register
  logic                          res_valid_q;
  logic                          drive_q, drive_d;
  logic                          mvalid_q, mvalid_d;
  msg_t                          msg_q, msg_d;
  logic                          dropped_q, dropped_d;

  logic                          accept;
  logic                          in_bit;
  logic [pwl_pkg::HeaderLen-1:0] header_upd;

  function automatic logic strictly_inside(input logic [pwl_pkg::PulseW-1:0] lo,
                                           input logic [pwl_pkg::PulseW-1:0] hi,
                                           input logic [pwl_pkg::PulseW-1:0] v);
    return (v > lo) && (v < hi);
  endfunction

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // A width inside the zero window reads as data zero
  assign in_bit  = !strictly_inside(zero_min_q, zero_max_q, req_i.pulse_width);
  assign rx_full = {in_bit, rx_q[pwl_pkg::MsgBits-1:1]};

  always_comb begin
    header_upd = header_q;
    header_upd[bitpos_q[$clog2(pwl_pkg::HeaderLen)-1:0]] = in_bit;
  end

  // Wrap head plus fill into the queue index range
  assign tail_sum = {1'b0, head_q} + fill_q[pwl_pkg::QIdxW:0];
  assign tail = (tail_sum >= (pwl_pkg::QIdxW+1)'(pwl_pkg::QueueDepth))
              ? pwl_pkg::QIdxW'(tail_sum - (pwl_pkg::QIdxW+1)'(pwl_pkg::QueueDepth))
              : tail_sum[pwl_pkg::QIdxW-1:0];

  always_comb begin
    phase_d   = phase_q;
    bitpos_d  = bitpos_q;
    header_d  = header_q;
    rx_d      = rx_q;
    tx_d      = tx_q;
    pending_d = pending_q;
    head_d    = head_q;
    fill_d    = fill_q;
    push      = 1'b0;
    drive_d   = 1'b0;
    mvalid_d  = 1'b0;
    msg_d     = '0;
    dropped_d = 1'b0;

    case (req_i.req_type)
      pwl_pkg::ReqPulse: begin
        case (phase_q)
          PhAwait: begin
            if (strictly_inside(presync_min_q, presync_max_q, req_i.pulse_width)) begin
              phase_d = PhPresync;
            end else begin
              header_d = '0;
              bitpos_d = '0;
            end
          end
          PhPresync: begin
            // The sync pulse doubles as remote header position 0
            if (strictly_inside(sync_min_q, sync_max_q, req_i.pulse_width)) begin
              phase_d  = PhRemoteHdr;
              bitpos_d = pwl_pkg::BitPosW'(1);
            end else begin
              phase_d  = PhAwait;
              header_d = '0;
              bitpos_d = '0;
            end
          end
          PhRemoteHdr: begin
            bitpos_d = bitpos_q + 1'b1;
            if (bitpos_q == pwl_pkg::BitPosW'(pwl_pkg::PosReady)) begin
              drive_d = ready_flag_q;
            end else if (bitpos_q == pwl_pkg::BitPosW'(pwl_pkg::PosPending)) begin
              drive_d = pending_q;
            end else if (bitpos_q == pwl_pkg::BitPosW'(pwl_pkg::PosInit)) begin
              drive_d = init_flag_q;
            end else if (bitpos_q >= pwl_pkg::BitPosW'(pwl_pkg::HeaderLen)) begin
              bitpos_d = '0;
              header_d = '0;
              phase_d  = PhPlayerHdr;
            end
          end
          PhPlayerHdr: begin
            header_d = header_upd;
            bitpos_d = bitpos_q + 1'b1;
            if (bitpos_q == pwl_pkg::BitPosW'(pwl_pkg::HeaderLen - 1)) begin
              bitpos_d = '0;
              if (!header_upd[pwl_pkg::HdrDataBit] && !header_upd[pwl_pkg::HdrCedeBit]) begin
                phase_d = PhReceive;
              end else if (header_upd[pwl_pkg::HdrCedeBit] && pending_q) begin
                phase_d = PhSend;
              end else begin
                phase_d = PhAwait;
              end
            end
          end
          PhSend: begin
            if (bitpos_q < pwl_pkg::BitPosW'(pwl_pkg::MsgBits)) begin
              // Shift out LSB first
              drive_d  = tx_q[0];
              tx_d     = {1'b0, tx_q[pwl_pkg::MsgBits-1:1]};
              bitpos_d = bitpos_q + 1'b1;
            end else begin
              pending_d = 1'b0;
              tx_d      = '0;
              header_d  = '0;
              bitpos_d  = '0;
              phase_d   = PhAwait;
            end
          end
          PhReceive: begin
            // Shift in at the top; after the last bit, bit 0 sits at position 0
            rx_d     = rx_full;
            bitpos_d = bitpos_q + 1'b1;
            if (bitpos_q == pwl_pkg::BitPosW'(pwl_pkg::MsgBits - 1)) begin
              if (fill_q < pwl_pkg::FillW'(pwl_pkg::QueueDepth)) begin
                push   = 1'b1;
                fill_d = fill_q + 1'b1;
              end else begin
                dropped_d = 1'b1;
              end
              rx_d     = '0;
              header_d = '0;
              bitpos_d = '0;
              phase_d  = PhAwait;
            end
          end
          default: begin
            header_d = '0;
            bitpos_d = '0;
            phase_d  = PhAwait;
          end
        endcase
      end
      pwl_pkg::ReqLoad: begin
        if (phase_q != PhSend) begin
          tx_d      = {req_i.out_high, req_i.out_low};
          pending_d = 1'b1;
        end
      end
      pwl_pkg::ReqPop: begin
        if (fill_q != '0) begin
          mvalid_d = 1'b1;
          msg_d    = store_q[head_q];
          head_d   = (head_q == pwl_pkg::QIdxW'(pwl_pkg::QueueDepth - 1))
                   ? '0 : head_q + 1'b1;
          fill_d   = fill_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presync_min_q <= '0;
      presync_max_q <= '0;
      sync_min_q    <= '0;
      sync_max_q    <= '0;
      zero_min_q    <= '0;
      zero_max_q    <= '0;
      ready_flag_q  <= 1'b1;
      init_flag_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pwl_pkg::CfgPresyncMin: presync_min_q <= cfg_data_i;
        pwl_pkg::CfgPresyncMax: presync_max_q <= cfg_data_i;
        pwl_pkg::CfgSyncMin:    sync_min_q    <= cfg_data_i;
        pwl_pkg::CfgSyncMax:    sync_max_q    <= cfg_data_i;
        pwl_pkg::CfgZeroMin:    zero_min_q    <= cfg_data_i;
        pwl_pkg::CfgZeroMax:    zero_max_q    <= cfg_data_i;
        pwl_pkg::CfgReady:      ready_flag_q  <= cfg_data_i[0];
        pwl_pkg::CfgInit:       init_flag_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhAwait;
      bitpos_q    <= '0;
      header_q    <= '0;
      rx_q        <= '0;
      tx_q        <= '0;
      pending_q   <= 1'b0;
      head_q      <= '0;
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        bitpos_q  <= bitpos_d;
        header_q  <= header_d;
        rx_q      <= rx_d;
        tx_q      <= tx_d;
        pending_q <= pending_d;
        head_q    <= head_d;
        fill_q    <= fill_d;
      end
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Queue storage and result payload
  always_ff @(posedge clk_i) begin
    if (accept && push) begin
      store_q[tail] <= rx_full;
    end
    if (accept) begin
      drive_q   <= drive_d;
      mvalid_q  <= mvalid_d;
      msg_q     <= msg_d;
      dropped_q <= dropped_d;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.drive_pulse = drive_q;
  assign res_o.msg_valid   = mvalid_q;
  assign res_o.msg_low     = msg_q[pwl_pkg::LowW-1:0];
  assign res_o.msg_high    = msg_q[pwl_pkg::MsgBits-1:pwl_pkg::LowW];
  assign res_o.dropped     = dropped_q;
  assign res_o.queue_level = pwl_pkg::LevelW'(fill_q);
  assign res_o.link_phase  = phase_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= pwl_pkg::FillW'(pwl_pkg::QueueDepth))
    else $error("queue fill exceeds depth");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> res_o.valid)
    else $error("transfer produced no result");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.dropped) |->
      (res_o.queue_level == pwl_pkg::LevelW'(pwl_pkg::QueueDepth)))
    else $error("message dropped while queue had room");

  a_drive_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.drive_pulse) |->
      (res_o.link_phase == PhRemoteHdr || res_o.link_phase == PhSend))
    else $error("pulse driven outside remote header or send");

endmodule

`default_nettype wire
